### sv/h4df_pkg.sv
// Package for the H4 receive deframer: packet kinds, status codes, type
// bytes, configuration defaults and the command passed from front to back.
// No dependencies.
package h4df_pkg;

  localparam int MAX_HEADER_BYTES = 4;
  localparam int HDR_IDX_W        = $clog2(MAX_HEADER_BYTES);
  localparam int HDR_W            = 8 * MAX_HEADER_BYTES;
  localparam int LENGTH_BITS      = 16;
  localparam int CFG_W            = 17;
  localparam int ERR_W            = 16;
  localparam int FIFO_DEPTH       = 8;

  localparam logic [CFG_W-1:0] MAX_FRAME_RESET = CFG_W'(1028);

  localparam logic [7:0] TYPE_EVENT = 8'h04;
  localparam logic [7:0] TYPE_ACL   = 8'h02;
  localparam logic [7:0] TYPE_SCO   = 8'h03;

  typedef enum logic [1:0] {
    KIND_EVENT = 2'd0,
    KIND_ACL   = 2'd1,
    KIND_SCO   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_FRAME    = 2'd0,
    ST_UNKNOWN  = 2'd1,
    ST_OVERSIZE = 2'd2
  } status_t;

  // One queue entry: a single result, or a header release of nb+1 bytes.
  typedef struct packed {
    logic                 hdr;
    logic [HDR_IDX_W-1:0] nb;
    logic [HDR_W-1:0]     bytes;
    kind_t                kind;
    logic                 last;
    status_t              status;
    logic [ERR_W-1:0]     err;
  } h4df_cmd_t;

  // Fixed header length of each packet kind.
  function automatic logic [HDR_IDX_W:0] hdr_size(kind_t k);
    logic [HDR_IDX_W:0] s;
    unique case (k)
      KIND_EVENT: s = (HDR_IDX_W+1)'(2);
      KIND_ACL:   s = (HDR_IDX_W+1)'(4);
      default:    s = (HDR_IDX_W+1)'(3);
    endcase
    return s;
  endfunction

endpackage

### sv/hci_uart_h4_deframer.sv
// Top level of the HCI UART H4 receive deframer: front parser, command
// queue and result back end. Uses h4df_pkg, h4df_front, h4df_fifo, h4df_back.
//
//  Port group  Dir  Payload (low bit first)                     Handshake
//  in_*        in   tdata: rx_byte[7:0]                         tvalid/tready
//  out_*       out  tdata: frame_byte[7:0], error_total[23:8]   tvalid/tready
//                   tuser: packet_kind[1:0], first_of_frame[2],
//                          status[4:3]; tlast: last_of_frame
//  cfg_*       in   wr_data: max_frame_bytes[16:0]              wr_en
//
// One byte is accepted per cycle while the queue has room. A byte that yields
// results pushes its queue command right away; while out_tready is high the
// back end emits one result per cycle, so a completed header releases its 2
// to 4 results one after another, via the queue and the output register.
// in_tready drops only while the command queue is full.
// Synchronous active-low reset returns the parser to waiting for a type
// byte, clears the error count and queue, and restores max_frame_bytes 1028.
module hci_uart_h4_deframer #(
  parameter int LENGTH_BITS = h4df_pkg::LENGTH_BITS,
  parameter int FIFO_DEPTH  = h4df_pkg::FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [16:0] cfg_wr_data,   // max_frame_bytes
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // rx_byte[7:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,     // frame_byte[7:0], error_total[23:8]
  output logic [4:0]  out_tuser,     // packet_kind[1:0], first_of_frame[2], status[4:3]
  output logic        out_tlast      // last_of_frame
);
  import h4df_pkg::*;

  logic      in_fire;
  logic      cmd_push;
  h4df_cmd_t cmd;
  h4df_cmd_t head;
  logic      q_empty;
  logic      q_full;
  logic      q_pop;

  // Accept whenever the queue has room; each byte pushes at most one entry.
  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && in_tready;

  h4df_front #(
    .LEN_BITS (LENGTH_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_fire     (in_fire),
    .in_byte     (in_tdata),
    .cmd_push    (cmd_push),
    .cmd         (cmd)
  );

  h4df_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_cmd (cmd),
    .pop      (q_pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  h4df_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .empty      (q_empty),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

### sv/h4df_front.sv
// Front part of the H4 deframer: parses type, header and payload bytes and
// emits one queue command per byte that yields results. Uses h4df_pkg.
module h4df_front #(
  parameter int LEN_BITS = h4df_pkg::LENGTH_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [h4df_pkg::CFG_W-1:0] cfg_wr_data,
  input  logic                     in_fire,
  input  logic [7:0]               in_byte,
  output logic                     cmd_push,
  output h4df_pkg::h4df_cmd_t      cmd
);
  import h4df_pkg::*;

  localparam int CMP_W = ((LEN_BITS + 1) > CFG_W) ? (LEN_BITS + 2) : (CFG_W + 1);

  typedef enum logic [1:0] {
    PH_TYPE,
    PH_HEADER,
    PH_DATA
  } phase_t;

  phase_t                phase_r, phase_nxt;
  kind_t                 kind_r, kind_nxt;
  logic [LEN_BITS-1:0]   rem_r, rem_nxt;
  logic [HDR_IDX_W-1:0]  idx_r, idx_nxt;
  logic [ERR_W-1:0]      err_r, err_nxt;
  logic [CFG_W-1:0]      max_frame_r;
  logic [7:0]            store_r [MAX_HEADER_BYTES];

  logic [HDR_W-1:0]      hdr_word;
  logic [HDR_IDX_W:0]    hs;
  logic                  hdr_done;
  logic [15:0]           len16;
  logic [CMP_W-1:0]      total;
  logic                  oversize;

  // Header as it stands with the current byte dropped into its slot.
  always_comb begin
    for (int i = 0; i < MAX_HEADER_BYTES; i++) begin
      hdr_word[8*i +: 8] = (HDR_IDX_W'(i) == idx_r) ? in_byte : store_r[i];
    end
  end

  assign hs       = hdr_size(kind_r);
  assign hdr_done = ({1'b0, idx_r} == hs - (HDR_IDX_W+1)'(1));

  always_comb begin
    unique case (kind_r)
      KIND_EVENT: len16 = {8'h00, hdr_word[15:8]};
      KIND_ACL:   len16 = hdr_word[31:16];
      default:    len16 = {8'h00, hdr_word[23:16]};
    endcase
  end

  assign total    = CMP_W'(hs) + CMP_W'(len16);
  assign oversize = (len16 != 16'd0) && (total > CMP_W'(max_frame_r));

  always_comb begin
    phase_nxt  = phase_r;
    kind_nxt   = kind_r;
    rem_nxt    = rem_r;
    idx_nxt    = idx_r;
    err_nxt    = err_r;
    cmd_push   = 1'b0;
    cmd.hdr    = 1'b0;
    cmd.nb     = '0;
    cmd.bytes  = HDR_W'(in_byte);
    cmd.kind   = kind_r;
    cmd.last   = 1'b0;
    cmd.status = ST_FRAME;
    cmd.err    = err_r;
    if (in_fire) begin
      unique case (phase_r)
        PH_HEADER: begin
          idx_nxt = idx_r + HDR_IDX_W'(1);
          if (hdr_done) begin
            idx_nxt  = '0;
            cmd_push = 1'b1;
            if (oversize) begin
              // Drop the frame, report it once.
              phase_nxt  = PH_TYPE;
              rem_nxt    = '0;
              cmd.bytes  = '0;
              cmd.status = ST_OVERSIZE;
            end else begin
              cmd.hdr   = 1'b1;
              cmd.nb    = HDR_IDX_W'(hs - (HDR_IDX_W+1)'(1));
              cmd.bytes = hdr_word;
              cmd.last  = (len16 == 16'd0);
              if (len16 == 16'd0) begin
                phase_nxt = PH_TYPE;
                rem_nxt   = '0;
              end else begin
                phase_nxt = PH_DATA;
                rem_nxt   = LEN_BITS'(len16);
              end
            end
          end
        end
        PH_DATA: begin
          cmd_push = 1'b1;
          cmd.last = (rem_r <= LEN_BITS'(1));
          if (rem_r <= LEN_BITS'(1)) begin
            phase_nxt = PH_TYPE;
            rem_nxt   = '0;
          end else begin
            rem_nxt = rem_r - LEN_BITS'(1);
          end
        end
        default: begin
          idx_nxt = '0;
          rem_nxt = '0;
          priority if (in_byte == TYPE_EVENT) begin
            kind_nxt  = KIND_EVENT;
            phase_nxt = PH_HEADER;
          end else if (in_byte == TYPE_ACL) begin
            kind_nxt  = KIND_ACL;
            phase_nxt = PH_HEADER;
          end else if (in_byte == TYPE_SCO) begin
            kind_nxt  = KIND_SCO;
            phase_nxt = PH_HEADER;
          end else begin
            // Unknown type: count it (saturating) and report.
            phase_nxt  = PH_TYPE;
            if (err_r != '1) begin
              err_nxt = err_r + ERR_W'(1);
            end
            cmd_push   = 1'b1;
            cmd.bytes  = '0;
            cmd.kind   = KIND_EVENT;
            cmd.status = ST_UNKNOWN;
            cmd.err    = err_nxt;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_TYPE;
      kind_r      <= KIND_EVENT;
      rem_r       <= '0;
      idx_r       <= '0;
      err_r       <= '0;
      max_frame_r <= MAX_FRAME_RESET;
    end else begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      rem_r   <= rem_nxt;
      idx_r   <= idx_nxt;
      err_r   <= err_nxt;
      if (cfg_wr_en) begin
        max_frame_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && phase_r == PH_HEADER) begin
      store_r[idx_r] <= in_byte;
    end
  end

endmodule

### sv/h4df_fifo.sv
// Short command queue between the deframer front and back parts.
// Uses h4df_pkg for the command type.
module h4df_fifo #(
  parameter int DEPTH = h4df_pkg::FIFO_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  h4df_pkg::h4df_cmd_t push_cmd,
  input  logic                pop,
  output h4df_pkg::h4df_cmd_t head,
  output logic                empty,
  output logic                full
);
  import h4df_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  h4df_cmd_t       mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]     count_r, count_nxt;
  logic            do_push, do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == (AW+1)'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH-1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH-1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + (AW+1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### sv/h4df_back.sv
// Back part of the H4 deframer: expands queued commands into result items
// and holds them in the output register. Uses h4df_pkg.
module h4df_back (
  input  logic                clk,
  input  logic                rst_n,
  input  h4df_pkg::h4df_cmd_t head,
  input  logic                empty,
  output logic                pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [23:0]         out_tdata,
  output logic [4:0]          out_tuser,
  output logic                out_tlast
);
  import h4df_pkg::*;

  logic                 valid_r;
  logic [7:0]           byte_r;
  kind_t                kind_r;
  logic                 first_r;
  logic                 last_r;
  status_t              status_r;
  logic [ERR_W-1:0]     err_r;
  logic [HDR_IDX_W-1:0] sub_r, sub_nxt;
  logic                 slot_free;
  logic                 load;

  assign slot_free = !valid_r || out_tready;
  assign load      = slot_free && !empty;
  assign pop       = load && (sub_r == head.nb);

  always_comb begin
    sub_nxt = sub_r;
    if (load) begin
      sub_nxt = (sub_r == head.nb) ? '0 : sub_r + HDR_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sub_r   <= '0;
    end else begin
      sub_r <= sub_nxt;
      if (slot_free) begin
        valid_r <= !empty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r   <= head.bytes[8*sub_r +: 8];
      kind_r   <= head.kind;
      first_r  <= head.hdr && (sub_r == '0);
      last_r   <= head.last && (sub_r == head.nb);
      status_r <= head.status;
      err_r    <= head.err;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {err_r, byte_r};
  assign out_tuser  = {status_r, first_r, kind_r};
  assign out_tlast  = last_r;

endmodule
